// ===== hdl/tvce_pkg.sv =====
// Shared types, constants and the arctangent table for the turtle vector
// command engine. No dependencies; used by every other file in hdl/.
`timescale 1ns / 1ps

package tvce_pkg;

  // Field widths
  localparam int OP_W      = 3;
  localparam int AMOUNT_W  = 21;
  localparam int SETTING_W = 8;
  localparam int COORD_W   = 16;
  localparam int GLYPH_W   = 8;
  localparam int FG_W      = 4;
  localparam int BG_W      = 3;

  localparam int S_DATA_W  = 32;  // amount + setting, padded to bytes
  localparam int M_DATA_W  = 80;  // four coords + glyph + colours, padded

  // Internal widths
  localparam int HEAD_W    = 17;  // Q.8 degrees, [0, 92160)
  localparam int REM_W     = 15;  // remainder inside one quadrant
  localparam int ACC_W     = 22;  // heading + amount before wrap
  localparam int PEN_W     = 32;  // Q16.16
  localparam int SPAN_W    = 20;  // length - 1
  localparam int TRIG_W    = 32;  // Q2.30
  localparam int XY_W      = TRIG_W + 2;
  localparam int Z_W       = 26;  // Q.16 degrees residual
  localparam int PROD_W    = SPAN_W + 1 + TRIG_W;
  localparam int DELTA_W   = PROD_W - 14;
  localparam int SUM_W     = DELTA_W + 1;
  localparam int ATAN_IDX_W = 5;
  localparam int ATAN_COUNT = 24;
  localparam int RED_W     = 2;   // wrap reduction steps: 8x, 4x, 2x, 1x turn

  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [HEAD_W-1:0] QUARTER_TURN = HEAD_W'(23040);
  localparam logic [HEAD_W-1:0] HALF_TURN    = HEAD_W'(46080);
  localparam logic [HEAD_W-1:0] THREE_QUARTER_TURN = HEAD_W'(69120);
  localparam int FULL_TURN = 92160;

  localparam logic signed [XY_W-1:0]   CORDIC_GAIN = XY_W'(652032874);
  localparam logic signed [TRIG_W-1:0] ONE_Q30     = TRIG_W'(1073741824);

  localparam logic [GLYPH_W-1:0] PATTERN_RST = 8'h2B;  // '+'
  localparam logic [FG_W-1:0]    FG_RST      = 4'd7;
  localparam logic [BG_W-1:0]    BG_RST      = 3'd0;

  typedef enum logic [OP_W-1:0] {
    OP_ROTATE  = 3'd0,
    OP_MOVE    = 3'd1,
    OP_DRAW    = 3'd2,
    OP_FORE    = 3'd3,
    OP_BACK    = 3'd4,
    OP_PATTERN = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT_FIX,
    ST_ROT_RED,
    ST_ROT_WR,
    ST_TRIG,
    ST_CORDIC,
    ST_QUAD,
    ST_MUL_C,
    ST_RND_C,
    ST_END_X,
    ST_END_Y,
    ST_ADV_X,
    ST_ADV_Y,
    ST_OUT
  } state_t;

  // Source of the value to be rounded into the delta register
  typedef enum logic [1:0] {
    DLT_PROD,
    DLT_COS,
    DLT_SIN
  } dlt_sel_t;

  // Which coordinate the saturating adder writes
  typedef enum logic [2:0] {
    WR_NONE,
    WR_END_X,
    WR_END_Y,
    WR_PEN_X,
    WR_PEN_Y
  } wr_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     acc_fix;
    logic     acc_red;
    logic     head_wr;
    logic     trig_load;
    logic     cordic_step;
    logic     quad_load;
    logic     mul_en;
    logic     mul_sin;
    logic     dlt_en;
    dlt_sel_t dlt_sel;
    wr_sel_t  wr_sel;
    logic     out_load;
  } tvce_ctrl_t;

  typedef struct packed {
    logic            in_valid;
    logic [OP_W-1:0] in_op;
    logic            len_pos;
    logic            exact;
    logic            cordic_last;
    logic            red_last;
    logic            out_free;
  } tvce_sts_t;

  // atan(2^-i) in Q.16 degrees, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] r;
    case (idx)
      5'd0:  r = Z_W'(2949120);
      5'd1:  r = Z_W'(1740967);
      5'd2:  r = Z_W'(919879);
      5'd3:  r = Z_W'(466945);
      5'd4:  r = Z_W'(234379);
      5'd5:  r = Z_W'(117304);
      5'd6:  r = Z_W'(58666);
      5'd7:  r = Z_W'(29335);
      5'd8:  r = Z_W'(14668);
      5'd9:  r = Z_W'(7334);
      5'd10: r = Z_W'(3667);
      5'd11: r = Z_W'(1833);
      5'd12: r = Z_W'(917);
      5'd13: r = Z_W'(458);
      5'd14: r = Z_W'(229);
      5'd15: r = Z_W'(115);
      5'd16: r = Z_W'(57);
      5'd17: r = Z_W'(29);
      5'd18: r = Z_W'(14);
      5'd19: r = Z_W'(7);
      5'd20: r = Z_W'(4);
      5'd21: r = Z_W'(2);
      5'd22: r = Z_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/tvce_cordic.sv =====
// Iterative CORDIC rotation unit: one micro-rotation per cycle while step is high.
// Depends on tvce_pkg.
`timescale 1ns / 1ps

module tvce_cordic #(
  parameter int CORDIC_STEPS = tvce_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 load,
  input  logic                                 step,
  input  logic [tvce_pkg::REM_W-1:0]           rem,
  output logic signed [tvce_pkg::TRIG_W-1:0]   cos_val,
  output logic signed [tvce_pkg::TRIG_W-1:0]   sin_val,
  output logic                                 last
);

  localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  logic signed [tvce_pkg::XY_W-1:0] x, y;
  logic signed [tvce_pkg::Z_W-1:0]  z;
  logic [STEP_W-1:0]                cnt;

  logic signed [tvce_pkg::XY_W-1:0] xs, ys;
  logic signed [tvce_pkg::Z_W-1:0]  at;

  assign xs   = y >>> cnt;
  assign ys   = x >>> cnt;
  assign at   = tvce_pkg::atan_q16(tvce_pkg::ATAN_IDX_W'(cnt));
  assign last = (cnt == STEP_W'(CORDIC_STEPS - 1));

  always_ff @(posedge clk) begin
    if (load) begin
      x   <= tvce_pkg::CORDIC_GAIN;
      y   <= '0;
      z   <= tvce_pkg::Z_W'({1'b0, rem, 8'h00});
      cnt <= '0;
    end else if (step) begin
      if (!z[tvce_pkg::Z_W-1]) begin
        x <= x - xs;
        y <= y + ys;
        z <= z - at;
      end else begin
        x <= x + xs;
        y <= y - ys;
        z <= z + at;
      end
      cnt <= cnt + STEP_W'(1);
    end
  end

  // magnitude stays near 1.0, so Q2.30 in 32 bits holds it
  assign cos_val = x[tvce_pkg::TRIG_W-1:0];
  assign sin_val = y[tvce_pkg::TRIG_W-1:0];

endmodule

// ===== hdl/tvce_seq.sv =====
// Command sequencer: walks one command through wrap, CORDIC, multiply and
// saturating-add steps. Depends on tvce_pkg.
`timescale 1ns / 1ps

module tvce_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  tvce_pkg::tvce_sts_t  sts,
  output tvce_pkg::tvce_ctrl_t ctrl
);

  tvce_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tvce_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tvce_pkg::ST_IDLE: begin
        if (sts.in_valid) begin
          unique case (sts.in_op) inside
            tvce_pkg::OP_ROTATE: state_next = tvce_pkg::ST_ROT_FIX;
            tvce_pkg::OP_MOVE, tvce_pkg::OP_DRAW: begin
              if (sts.len_pos) state_next = tvce_pkg::ST_TRIG;
            end
            default: state_next = tvce_pkg::ST_IDLE;
          endcase
        end
      end
      tvce_pkg::ST_ROT_FIX: state_next = tvce_pkg::ST_ROT_RED;
      tvce_pkg::ST_ROT_RED: begin
        if (sts.red_last) state_next = tvce_pkg::ST_ROT_WR;
      end
      tvce_pkg::ST_ROT_WR: state_next = tvce_pkg::ST_IDLE;
      tvce_pkg::ST_TRIG: begin
        state_next = sts.exact ? tvce_pkg::ST_QUAD : tvce_pkg::ST_CORDIC;
      end
      tvce_pkg::ST_CORDIC: begin
        if (sts.cordic_last) state_next = tvce_pkg::ST_QUAD;
      end
      tvce_pkg::ST_QUAD:  state_next = tvce_pkg::ST_MUL_C;
      tvce_pkg::ST_MUL_C: state_next = tvce_pkg::ST_RND_C;
      tvce_pkg::ST_RND_C: state_next = tvce_pkg::ST_END_X;
      tvce_pkg::ST_END_X: state_next = tvce_pkg::ST_END_Y;
      tvce_pkg::ST_END_Y: state_next = tvce_pkg::ST_ADV_X;
      tvce_pkg::ST_ADV_X: state_next = tvce_pkg::ST_ADV_Y;
      tvce_pkg::ST_ADV_Y: state_next = tvce_pkg::ST_OUT;
      tvce_pkg::ST_OUT: begin
        if (sts.out_free) state_next = tvce_pkg::ST_IDLE;
      end
      default: state_next = tvce_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.dlt_sel = tvce_pkg::DLT_PROD;
    ctrl.wr_sel  = tvce_pkg::WR_NONE;
    unique case (state)
      tvce_pkg::ST_IDLE:    ctrl.in_ready = 1'b1;
      tvce_pkg::ST_ROT_FIX: ctrl.acc_fix = 1'b1;
      tvce_pkg::ST_ROT_RED: ctrl.acc_red = 1'b1;
      tvce_pkg::ST_ROT_WR:  ctrl.head_wr = 1'b1;
      tvce_pkg::ST_TRIG:    ctrl.trig_load = 1'b1;
      tvce_pkg::ST_CORDIC:  ctrl.cordic_step = 1'b1;
      tvce_pkg::ST_QUAD:    ctrl.quad_load = 1'b1;
      tvce_pkg::ST_MUL_C:   ctrl.mul_en = 1'b1;
      tvce_pkg::ST_RND_C: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sin = 1'b1;
        ctrl.dlt_en  = 1'b1;
      end
      tvce_pkg::ST_END_X: begin
        ctrl.wr_sel = tvce_pkg::WR_END_X;
        ctrl.dlt_en = 1'b1;
      end
      tvce_pkg::ST_END_Y: begin
        ctrl.wr_sel  = tvce_pkg::WR_END_Y;
        ctrl.dlt_en  = 1'b1;
        ctrl.dlt_sel = tvce_pkg::DLT_COS;
      end
      tvce_pkg::ST_ADV_X: begin
        ctrl.wr_sel  = tvce_pkg::WR_PEN_X;
        ctrl.dlt_en  = 1'b1;
        ctrl.dlt_sel = tvce_pkg::DLT_SIN;
      end
      tvce_pkg::ST_ADV_Y: ctrl.wr_sel = tvce_pkg::WR_PEN_Y;
      tvce_pkg::ST_OUT:   ctrl.out_load = sts.out_free;
      default: ctrl.in_ready = 1'b0;
    endcase
  end

endmodule

// ===== hdl/turtle_vector_command_engine.sv =====
// Top level of the turtle vector command engine: stream ports, turtle state
// and the shared multiply / round / saturating-add datapath.
// Depends on tvce_pkg, tvce_cordic and tvce_seq.
`timescale 1ns / 1ps

// Channel  Dir  Bus                      Contents
// -------  ---  -----------------------  -----------------------------------------
// s_*      in   tvalid/tready/tdata/tuser one turtle command per transaction
// m_*      out  tvalid/tready/tdata/tuser one line segment per move/draw command
//
// Steps: set fg/bg/pattern, unknown ops and move/draw of length <= 0 are done in
// the idle state on acceptance. Rotate runs sum, sign fix of 16 full turns, four
// conditional subtracts of 8, 4, 2 and 1 full turns, and write back. Move/draw
// runs the CORDIC iterations, quadrant fold, multiply, round, end and pen updates
// and output load; headings on an exact multiple of 90 degrees skip the CORDIC.
// Reset (rst, synchronous): heading 0, pen at origin, pattern '+', fg 7, bg 0.
// s_tready is high only while the sequencer is idle. A segment sits in the
// output register until taken; a new command is accepted meanwhile, and a
// following move/draw waits in its last step only if that register is full.

module turtle_vector_command_engine #(
  parameter int CORDIC_STEPS = tvce_pkg::CORDIC_STEPS_DEF  // 8 .. 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [tvce_pkg::S_DATA_W-1:0]   s_tdata,   // amount[20:0], setting[28:21]
  input  logic [tvce_pkg::OP_W-1:0]       s_tuser,   // op[2:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [tvce_pkg::M_DATA_W-1:0]   m_tdata,   // start_x[15:0], start_y[31:16],
                                                     // end_x[47:32], end_y[63:48],
                                                     // glyph[71:64], fore_colour[75:72],
                                                     // back_colour[78:76]
  output logic                            m_tuser    // pen_on[0]
);

  tvce_pkg::tvce_ctrl_t ctrl;
  tvce_pkg::tvce_sts_t  sts;

  // ---------------------------------------------------------------- input
  logic [tvce_pkg::OP_W-1:0]             in_op;
  logic signed [tvce_pkg::AMOUNT_W-1:0]  in_amount;
  logic [tvce_pkg::SETTING_W-1:0]        in_setting;
  logic                                  accept;

  assign in_op      = s_tuser;
  assign in_amount  = s_tdata[tvce_pkg::AMOUNT_W-1:0];
  assign in_setting = s_tdata[tvce_pkg::AMOUNT_W +: tvce_pkg::SETTING_W];
  assign s_tready   = ctrl.in_ready;
  assign accept     = s_tvalid && ctrl.in_ready;

  // ---------------------------------------------------------------- turtle state
  logic [tvce_pkg::HEAD_W-1:0]        heading;
  logic signed [tvce_pkg::PEN_W-1:0]  pen_x, pen_y;
  logic [tvce_pkg::GLYPH_W-1:0]       pattern_byte;
  logic [tvce_pkg::FG_W-1:0]          fg_index;
  logic [tvce_pkg::BG_W-1:0]          bg_index;

  // working registers
  logic                                 pen_on;
  logic [tvce_pkg::SPAN_W-1:0]          span;
  logic signed [tvce_pkg::ACC_W-1:0]    acc;
  logic [tvce_pkg::RED_W-1:0]           red_k;
  logic [1:0]                           quad;
  logic                                 exact;
  logic signed [tvce_pkg::TRIG_W-1:0]   cs, sn;
  logic signed [tvce_pkg::PROD_W-1:0]   prod;
  logic signed [tvce_pkg::DELTA_W-1:0]  delta;
  logic signed [tvce_pkg::PEN_W-1:0]    end_x, end_y;
  logic [tvce_pkg::COORD_W-1:0]         start_x, start_y;

  // ---------------------------------------------------------------- helpers
  // Round Q30 product to Q16, half away from zero
  function automatic logic signed [tvce_pkg::DELTA_W-1:0] round14(
    input logic signed [tvce_pkg::PROD_W-1:0] v
  );
    logic signed [tvce_pkg::PROD_W-1:0] t;
    t = v + (v[tvce_pkg::PROD_W-1] ? tvce_pkg::PROD_W'(8191) : tvce_pkg::PROD_W'(8192));
    return tvce_pkg::DELTA_W'(t >>> 14);
  endfunction

  // Q16.16 to integer pixel, half away from zero, clamped to 16 bits
  function automatic logic [tvce_pkg::COORD_W-1:0] coord_out(
    input logic signed [tvce_pkg::PEN_W-1:0] p
  );
    logic signed [tvce_pkg::PEN_W:0] t;
    logic signed [tvce_pkg::PEN_W:0] r;
    t = (tvce_pkg::PEN_W+1)'(p) +
        (p[tvce_pkg::PEN_W-1] ? (tvce_pkg::PEN_W+1)'(32767) : (tvce_pkg::PEN_W+1)'(32768));
    r = t >>> 16;
    // only +32768 can fall outside the range
    if (!r[tvce_pkg::PEN_W] && r[tvce_pkg::COORD_W-1]) begin
      return 16'h7FFF;
    end
    return r[tvce_pkg::COORD_W-1:0];
  endfunction

  // ---------------------------------------------------------------- heading split
  logic [1:0]                   quad_now;
  logic [tvce_pkg::HEAD_W-1:0]  rem_full;
  logic [tvce_pkg::REM_W-1:0]   rem_now;

  always_comb begin
    if (heading >= tvce_pkg::THREE_QUARTER_TURN) begin
      quad_now = 2'd3;
      rem_full = heading - tvce_pkg::THREE_QUARTER_TURN;
    end else if (heading >= tvce_pkg::HALF_TURN) begin
      quad_now = 2'd2;
      rem_full = heading - tvce_pkg::HALF_TURN;
    end else if (heading >= tvce_pkg::QUARTER_TURN) begin
      quad_now = 2'd1;
      rem_full = heading - tvce_pkg::QUARTER_TURN;
    end else begin
      quad_now = 2'd0;
      rem_full = heading;
    end
  end
  assign rem_now = rem_full[tvce_pkg::REM_W-1:0];

  // ---------------------------------------------------------------- CORDIC
  logic signed [tvce_pkg::TRIG_W-1:0] cordic_cos, cordic_sin;
  logic                               cordic_last;

  tvce_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .load    (ctrl.trig_load),
    .step    (ctrl.cordic_step),
    .rem     (rem_now),
    .cos_val (cordic_cos),
    .sin_val (cordic_sin),
    .last    (cordic_last)
  );

  // ---------------------------------------------------------------- sequencer
  assign sts.in_valid    = s_tvalid;
  assign sts.in_op       = in_op;
  assign sts.len_pos     = !in_amount[tvce_pkg::AMOUNT_W-1] && (|in_amount);
  assign sts.exact       = (rem_now == '0);
  assign sts.cordic_last = cordic_last;
  assign sts.red_last    = (red_k == '0);
  assign sts.out_free    = !m_tvalid || m_tready;

  tvce_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .sts  (sts),
    .ctrl (ctrl)
  );

  // ---------------------------------------------------------------- rotate wrap
  logic signed [tvce_pkg::ACC_W-1:0] red_turn;
  assign red_turn = tvce_pkg::ACC_W'(tvce_pkg::FULL_TURN) << red_k;

  always_ff @(posedge clk) begin
    if (accept) begin
      acc <= tvce_pkg::ACC_W'(signed'({1'b0, heading})) + tvce_pkg::ACC_W'(in_amount);
    end else if (ctrl.acc_fix) begin
      // most negative sum is above -16 turns; lift it into [0, 16 turns)
      if (acc[tvce_pkg::ACC_W-1]) begin
        acc <= acc + tvce_pkg::ACC_W'(tvce_pkg::FULL_TURN * 16);
      end
      red_k <= '1;
    end else if (ctrl.acc_red) begin
      if (acc >= red_turn) begin
        acc <= acc - red_turn;
      end
      red_k <= red_k - tvce_pkg::RED_W'(1);
    end
  end

  // ---------------------------------------------------------------- command latch
  always_ff @(posedge clk) begin
    if (accept) begin
      span   <= in_amount[tvce_pkg::SPAN_W-1:0] - tvce_pkg::SPAN_W'(1);
      pen_on <= (in_op == tvce_pkg::OP_DRAW);
    end
    if (ctrl.trig_load) begin
      quad    <= quad_now;
      exact   <= (rem_now == '0);
      start_x <= coord_out(pen_x);
      start_y <= coord_out(pen_y);
    end
  end

  // ---------------------------------------------------------------- quadrant fold
  logic signed [tvce_pkg::TRIG_W-1:0] c0, s0;
  assign c0 = exact ? tvce_pkg::ONE_Q30 : cordic_cos;
  assign s0 = exact ? '0 : cordic_sin;

  always_ff @(posedge clk) begin
    if (ctrl.quad_load) begin
      case (quad)
        2'd0: begin cs <= c0;  sn <= s0;  end
        2'd1: begin cs <= -s0; sn <= c0;  end
        2'd2: begin cs <= -c0; sn <= -s0; end
        default: begin cs <= s0; sn <= -c0; end
      endcase
    end
  end

  // ---------------------------------------------------------------- multiply, round
  logic signed [tvce_pkg::TRIG_W-1:0]  mul_b;
  logic signed [tvce_pkg::SPAN_W:0]    mul_a;
  logic signed [tvce_pkg::PROD_W-1:0]  rnd_in;

  assign mul_a = signed'({1'b0, span});
  assign mul_b = ctrl.mul_sin ? sn : cs;

  always_comb begin
    case (ctrl.dlt_sel)
      tvce_pkg::DLT_COS: rnd_in = tvce_pkg::PROD_W'(cs);
      tvce_pkg::DLT_SIN: rnd_in = tvce_pkg::PROD_W'(sn);
      default:           rnd_in = prod;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= tvce_pkg::PROD_W'(mul_a * mul_b);
    end
    if (ctrl.dlt_en) begin
      delta <= round14(rnd_in);
    end
  end

  // ---------------------------------------------------------------- saturating adder
  // end = pen + delta (x) / pen - delta (y); pen = end + step likewise
  logic signed [tvce_pkg::PEN_W-1:0] add_base;
  logic                              add_sub;
  logic signed [tvce_pkg::SUM_W-1:0] add_sum;
  logic signed [tvce_pkg::PEN_W-1:0] add_sat;

  always_comb begin
    case (ctrl.wr_sel)
      tvce_pkg::WR_END_X: begin add_base = pen_x; add_sub = 1'b0; end
      tvce_pkg::WR_END_Y: begin add_base = pen_y; add_sub = 1'b1; end
      tvce_pkg::WR_PEN_X: begin add_base = end_x; add_sub = 1'b0; end
      tvce_pkg::WR_PEN_Y: begin add_base = end_y; add_sub = 1'b1; end
      default:            begin add_base = pen_x; add_sub = 1'b0; end
    endcase
    add_sum = tvce_pkg::SUM_W'(add_base) +
              (add_sub ? -tvce_pkg::SUM_W'(delta) : tvce_pkg::SUM_W'(delta));
    if (!add_sum[tvce_pkg::SUM_W-1] && (|add_sum[tvce_pkg::SUM_W-2:tvce_pkg::PEN_W-1])) begin
      add_sat = {1'b0, {(tvce_pkg::PEN_W-1){1'b1}}};
    end else if (add_sum[tvce_pkg::SUM_W-1] &&
                 !(&add_sum[tvce_pkg::SUM_W-2:tvce_pkg::PEN_W-1])) begin
      add_sat = {1'b1, {(tvce_pkg::PEN_W-1){1'b0}}};
    end else begin
      add_sat = add_sum[tvce_pkg::PEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_sel == tvce_pkg::WR_END_X) end_x <= add_sat;
    if (ctrl.wr_sel == tvce_pkg::WR_END_Y) end_y <= add_sat;
  end

  // ---------------------------------------------------------------- architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      heading      <= '0;
      pen_x        <= '0;
      pen_y        <= '0;
      pattern_byte <= tvce_pkg::PATTERN_RST;
      fg_index     <= tvce_pkg::FG_RST;
      bg_index     <= tvce_pkg::BG_RST;
    end else begin
      if (accept) begin
        case (in_op)
          tvce_pkg::OP_FORE:    fg_index     <= in_setting[tvce_pkg::FG_W-1:0];
          tvce_pkg::OP_BACK:    bg_index     <= in_setting[tvce_pkg::BG_W-1:0];
          tvce_pkg::OP_PATTERN: pattern_byte <= in_setting;
          default: ;
        endcase
      end
      if (ctrl.head_wr) heading <= acc[tvce_pkg::HEAD_W-1:0];
      if (ctrl.wr_sel == tvce_pkg::WR_PEN_X) pen_x <= add_sat;
      if (ctrl.wr_sel == tvce_pkg::WR_PEN_Y) pen_y <= add_sat;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      m_tdata <= {1'b0, bg_index, fg_index, pattern_byte,
                  coord_out(end_y), coord_out(end_x), start_y, start_x};
      m_tuser <= pen_on;
    end
  end

endmodule

// ===== tb/tb_turtle_vector_command_engine.sv =====
// Self-checking testbench for turtle_vector_command_engine: random-timed stream
// traffic, an in-bench turtle predictor and an in-order segment scoreboard.
// Depends on tvce_pkg and the engine RTL in hdl/.
`timescale 1ns / 1ps

module tb_turtle_vector_command_engine;

  localparam int CORDIC_ITERS   = 16;
  localparam int RANDOM_CMDS    = 1030;   // commands that do something
  localparam int WATCHDOG_LIMIT = 4000;   // cycles with no transaction at all
  localparam int DRAIN_CYCLES   = 60;     // > one full move/draw pass
  localparam int LONG_HOLD      = 300;    // sink back-pressure stretch

  // Op codes the engine must ignore
  localparam logic [tvce_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [tvce_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;

  // Angles in Q.8 degrees, trig in Q2.30, pen in Q16.16
  localparam int     TURN_Q8    = 92160;
  localparam int     QUARTER_Q8 = 23040;
  localparam longint UNIT_Q30   = 64'sd1073741824;
  localparam longint GAIN_Q30   = 64'sd652032874;
  localparam longint PEN_HI     = 64'sd2147483647;
  localparam longint PEN_LO     = -64'sd2147483648;

  typedef struct packed {
    logic signed [tvce_pkg::COORD_W-1:0] start_x;
    logic signed [tvce_pkg::COORD_W-1:0] start_y;
    logic signed [tvce_pkg::COORD_W-1:0] end_x;
    logic signed [tvce_pkg::COORD_W-1:0] end_y;
    logic                                pen_on;
    logic [tvce_pkg::GLYPH_W-1:0]        glyph;
    logic [tvce_pkg::FG_W-1:0]           fore;
    logic [tvce_pkg::BG_W-1:0]           back;
  } segment_t;

  // ---------------------------------------------------------------------------
  // Turtle predictor plus queue of segments still owed by the engine.
  // ---------------------------------------------------------------------------
  class segment_board;
    int                           heading;        // Q.8 degrees, [0, TURN_Q8)
    int                           pen_x, pen_y;   // Q16.16
    logic [tvce_pkg::GLYPH_W-1:0] glyph;
    logic [tvce_pkg::FG_W-1:0]    fore;
    logic [tvce_pkg::BG_W-1:0]    back;
    segment_t                     due[$];
    int errors, checked;
    int n_rotate, n_setting, n_ignored, n_segment;

    function new();
      heading = 0;
      pen_x   = 0;
      pen_y   = 0;
      glyph   = 8'h2B;   // '+'
      fore    = 4'd7;
      back    = 3'd0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    // atan(2^-i) in Q.16 degrees
    function longint atan_q16(int i);
      case (i)
        0: return 2949120;  1: return 1740967;  2: return 919879;  3: return 466945;
        4: return 234379;   5: return 117304;   6: return 58666;   7: return 29335;
        8: return 14668;    9: return 7334;    10: return 3667;   11: return 1833;
        12: return 917;    13: return 458;     14: return 229;    15: return 115;
        16: return 57;     17: return 29;      18: return 14;     19: return 7;
        20: return 4;      21: return 2;       22: return 1;
        default: return 0;
      endcase
    endfunction

    // shift right, rounding half away from zero
    function longint round_away(longint v, int sh);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
      return (v < 0) ? -m : m;
    endfunction

    function int clamp_pen(longint v);
      if (v > PEN_HI) return int'(PEN_HI);
      if (v < PEN_LO) return int'(PEN_LO);
      return int'(v);
    endfunction

    function logic signed [tvce_pkg::COORD_W-1:0] to_cell(int p);
      longint r;
      r = round_away(longint'(p), 16);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return tvce_pkg::COORD_W'(r);
    endfunction

    // cos/sin of the heading in Q2.30; axis headings are exact
    function void heading_trig(output longint c, output longint s);
      int     quad, rem;
      longint c0, s0, x, y, z, xs, ys;
      quad = heading / QUARTER_Q8;
      rem  = heading % QUARTER_Q8;
      if (rem == 0) begin
        c0 = UNIT_Q30;
        s0 = 0;
      end else begin
        x = GAIN_Q30;
        y = 0;
        z = longint'(rem) * 256;
        for (int i = 0; i < CORDIC_ITERS && i < 24; i++) begin
          xs = y >>> i;
          ys = x >>> i;
          if (z >= 0) begin
            x = x - xs; y = y + ys; z = z - atan_q16(i);
          end else begin
            x = x + xs; y = y - ys; z = z + atan_q16(i);
          end
        end
        c0 = x;
        s0 = y;
      end
      case (quad)
        0: begin c = c0;  s = s0;  end
        1: begin c = -s0; s = c0;  end
        2: begin c = -c0; s = -s0; end
        default: begin c = s0; s = -c0; end
      endcase
    endfunction

    // Apply one accepted command; queue the segment it owes, if any
    function void note_command(logic [tvce_pkg::OP_W-1:0] op,
                               logic signed [tvce_pkg::AMOUNT_W-1:0] amount,
                               logic [tvce_pkg::SETTING_W-1:0] setting);
      longint   sum, span, c, s;
      int       sx, sy, ex, ey;
      segment_t seg;
      case (op)
        tvce_pkg::OP_ROTATE: begin
          sum = (longint'(heading) + longint'(amount)) % TURN_Q8;
          if (sum < 0) sum = sum + TURN_Q8;
          heading = int'(sum);
          n_rotate++;
        end
        tvce_pkg::OP_FORE: begin
          fore = setting[tvce_pkg::FG_W-1:0];
          n_setting++;
        end
        tvce_pkg::OP_BACK: begin
          back = setting[tvce_pkg::BG_W-1:0];
          n_setting++;
        end
        tvce_pkg::OP_PATTERN: begin
          glyph = setting;
          n_setting++;
        end
        tvce_pkg::OP_MOVE, tvce_pkg::OP_DRAW: begin
          if (amount > 0) begin
            span = longint'(amount) - 1;
            sx = pen_x;
            sy = pen_y;
            heading_trig(c, s);
            ex = clamp_pen(longint'(sx) + round_away(span * c, 14));
            ey = clamp_pen(longint'(sy) - round_away(span * s, 14));
            pen_x = clamp_pen(longint'(ex) + round_away(c, 14));
            pen_y = clamp_pen(longint'(ey) - round_away(s, 14));
            seg.start_x = to_cell(sx);
            seg.start_y = to_cell(sy);
            seg.end_x   = to_cell(ex);
            seg.end_y   = to_cell(ey);
            seg.pen_on  = (op == tvce_pkg::OP_DRAW);
            seg.glyph   = glyph;
            seg.fore    = fore;
            seg.back    = back;
            due.push_back(seg);
            n_segment++;
          end else begin
            n_ignored++;
          end
        end
        default: n_ignored++;
      endcase
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      errors++;
    endtask

    task check_field(string name, longint got, longint want);
      if (got != want)
        report_mismatch($sformatf("segment %0d %s: got %0d, expected %0d",
                                  checked, name, got, want));
    endtask

    task check_segment(segment_t got);
      segment_t want;
      if (due.size() == 0) begin
        report_mismatch($sformatf("segment %0d arrived with none outstanding", checked));
      end else begin
        want = due.pop_front();
        check_field("start_x", longint'(got.start_x), longint'(want.start_x));
        check_field("start_y", longint'(got.start_y), longint'(want.start_y));
        check_field("end_x",   longint'(got.end_x),   longint'(want.end_x));
        check_field("end_y",   longint'(got.end_y),   longint'(want.end_y));
        check_field("pen_on",  got.pen_on, want.pen_on);
        check_field("glyph",   got.glyph,  want.glyph);
        check_field("fore",    got.fore,   want.fore);
        check_field("back",    got.back,   want.back);
      end
      checked++;
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic                          clk      = 1'b0;
  logic                          rst      = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [tvce_pkg::S_DATA_W-1:0] s_tdata  = '0;   // amount[20:0], setting[28:21]
  logic [tvce_pkg::OP_W-1:0]     s_tuser  = '0;   // op[2:0]
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [tvce_pkg::M_DATA_W-1:0] m_tdata;         // start_x, start_y, end_x, end_y,
                                                  // glyph, fore_colour, back_colour
                                                  // (low bit up)
  logic                          m_tuser;         // pen_on

  segment_board board = new();

  int n_sent;      // commands accepted by the engine
  int n_taken;     // segments accepted from the engine
  int quiet;       // watchdog: cycles since the last transaction

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  turtle_vector_command_engine #(.CORDIC_STEPS(CORDIC_ITERS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // ---------------------------------------------------------------------------
  // Watchdog: a correct run never goes this long without a transaction; the
  // longest legal silence is the sink hold plus one move/draw pass.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $time, quiet);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Command source
  // ---------------------------------------------------------------------------

  // Bursts of back-to-back commands between stretches of random gaps
  function automatic int source_gap(int idx);
    return (idx % 128 < 24) ? 0 : int'($urandom_range(0, 10));
  endfunction

  // One command transaction. Valid stays up across back-to-back commands, so
  // each edge sees at most one assignment to it.
  task automatic offer_command(logic [tvce_pkg::OP_W-1:0] op, int amount,
                               logic [tvce_pkg::SETTING_W-1:0] setting, int gap);
    logic signed [tvce_pkg::AMOUNT_W-1:0] amt;
    amt = tvce_pkg::AMOUNT_W'(amount);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, setting, amt};
    do @(posedge clk); while (!s_tready);
    board.note_command(op, amt, setting);
    n_sent++;
  endtask

  // Random command mix. Rotates favor axis headings (incl. snapping back onto
  // one) so both the exact path and the CORDIC path get plenty of segments;
  // lengths are mostly short to keep the pen away from the rails.
  task automatic pick_command(output logic [tvce_pkg::OP_W-1:0] op, output int amount,
                              output logic [tvce_pkg::SETTING_W-1:0] setting,
                              output bit counts);
    int r, k;
    r       = $urandom_range(0, 99);
    setting = tvce_pkg::SETTING_W'($urandom_range(0, 255));
    amount  = int'($urandom());
    counts  = 1'b1;
    if (r < 28) begin
      op = tvce_pkg::OP_ROTATE;
      k  = $urandom_range(0, 8);
      case (k)
        0, 1, 2: amount = (int'($urandom_range(0, 12)) - 4) * QUARTER_Q8;
        3:       amount = -(board.heading % QUARTER_Q8)
                          + int'($urandom_range(0, 3)) * QUARTER_Q8;
        4, 5:    amount = int'($urandom_range(0, 2 * TURN_Q8)) - TURN_Q8;
        6:       amount = int'($urandom_range(0, 600)) - 300;
        default: ;   // full 21-bit range
      endcase
    end else if (r < 68) begin
      op = $urandom_range(0, 1) ? tvce_pkg::OP_DRAW : tvce_pkg::OP_MOVE;
      k  = $urandom_range(0, 99);
      if (k < 75)      amount = $urandom_range(1, 64);
      else if (k < 88) amount = $urandom_range(65, 4000);
      else if (k < 93) amount = -int'($urandom_range(0, 20));
      else if (k < 96) amount = int'(tvce_pkg::AMOUNT_W'(amount));
      else             amount = $urandom_range(1, 3);
      // sign-extend to see whether the engine will actually draw
      counts = (int'($signed(tvce_pkg::AMOUNT_W'(amount))) > 0);
    end else if (r < 94) begin
      k = $urandom_range(0, 2);
      op = (k == 0) ? tvce_pkg::OP_FORE : (k == 1) ? tvce_pkg::OP_BACK : tvce_pkg::OP_PATTERN;
    end else begin
      op     = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
      counts = 1'b0;
    end
  endtask

  task automatic run_commands();
    logic [tvce_pkg::OP_W-1:0]      op;
    logic [tvce_pkg::SETTING_W-1:0] setting;
    int                             amount, done;
    bit                             counts, paused;

    // Directed: length one, non-positive lengths, out-of-range colours, space
    // and extreme pattern bytes, the 0 and 90 degree axes, wrap in both directions
    // beyond a full turn, the amount extremes, a CORDIC heading, ignored op codes
    // and a pen run into saturation and back.
    offer_command(tvce_pkg::OP_DRAW,    1,               8'h00, source_gap(0));
    offer_command(tvce_pkg::OP_MOVE,    0,               8'hFF, source_gap(1));
    offer_command(tvce_pkg::OP_DRAW,    -5,              8'h00, source_gap(2));
    offer_command(tvce_pkg::OP_FORE,    0,               8'h0F, source_gap(3));
    offer_command(tvce_pkg::OP_FORE,    0,               8'hF3, source_gap(4));
    offer_command(tvce_pkg::OP_BACK,    0,               8'h07, source_gap(5));
    offer_command(tvce_pkg::OP_BACK,    0,               8'hFD, source_gap(6));
    offer_command(tvce_pkg::OP_PATTERN, 0,               8'h20, source_gap(7));
    offer_command(tvce_pkg::OP_DRAW,    10,              8'h00, source_gap(8));
    offer_command(tvce_pkg::OP_ROTATE,  QUARTER_Q8,      8'h00, source_gap(9));
    offer_command(tvce_pkg::OP_DRAW,    7,               8'h00, source_gap(10));
    offer_command(tvce_pkg::OP_ROTATE,  -5 * QUARTER_Q8, 8'h00, source_gap(11));
    offer_command(tvce_pkg::OP_MOVE,    3,               8'h00, source_gap(12));
    offer_command(tvce_pkg::OP_ROTATE,  1048575,         8'h00, source_gap(13));
    offer_command(tvce_pkg::OP_DRAW,    25,              8'h00, source_gap(14));
    offer_command(tvce_pkg::OP_ROTATE,  -1048576,        8'h00, source_gap(15));
    offer_command(OP_SPARE_A,           1048575,         8'hFF, source_gap(16));
    offer_command(OP_SPARE_B,           -1048576,        8'h5A, source_gap(17));
    offer_command(tvce_pkg::OP_PATTERN, 0,               8'hFF, source_gap(18));
    offer_command(tvce_pkg::OP_ROTATE,  -(board.heading % QUARTER_Q8) + QUARTER_Q8 / 2,
                  8'h00, source_gap(19));
    offer_command(tvce_pkg::OP_DRAW,    100,             8'h00, source_gap(20));
    offer_command(tvce_pkg::OP_PATTERN, 0,               8'h00, source_gap(21));
    offer_command(tvce_pkg::OP_ROTATE,  256,             8'h00, source_gap(22));
    offer_command(tvce_pkg::OP_DRAW,    1048575,         8'h00, source_gap(23));
    offer_command(tvce_pkg::OP_ROTATE,  TURN_Q8 / 2,     8'h00, source_gap(24));
    offer_command(tvce_pkg::OP_MOVE,    1048575,         8'h00, source_gap(25));

    done   = 0;
    paused = 1'b0;
    while (done < RANDOM_CMDS) begin
      // Once, let the engine drain completely before carrying on
      if (!paused && done == RANDOM_CMDS / 2) begin
        paused = 1'b1;
        s_tvalid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
      end
      pick_command(op, amount, setting, counts);
      offer_command(op, amount, setting, source_gap(n_sent));
      if (counts) done++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Segment sink: random stalls with stall-free stretches, plus two long holds
  // while commands keep coming so the output register fills and the engine
  // stops taking input.
  // ---------------------------------------------------------------------------
  task automatic collect_segments();
    int       stall;
    segment_t got;
    forever begin
      stall = (n_taken % 100 < 20) ? 0 : int'($urandom_range(0, 10));
      if (n_taken == 40 || n_taken == 400) stall = LONG_HOLD;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.start_x = m_tdata[15:0];
      got.start_y = m_tdata[31:16];
      got.end_x   = m_tdata[47:32];
      got.end_y   = m_tdata[63:48];
      got.glyph   = m_tdata[71:64];
      got.fore    = m_tdata[75:72];
      got.back    = m_tdata[78:76];
      got.pen_on  = m_tuser;
      board.check_segment(got);
      n_taken++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    fork
      collect_segments();
    join_none
    run_commands();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    // anything extra the engine still emits lands here as an unexpected segment
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d commands (%0d rotates, %0d colour/pattern, %0d ignored)",
             n_sent, board.n_rotate, board.n_setting, board.n_ignored);
    $display("     %0d of %0d segments checked, %0d mismatches",
             board.checked, board.n_segment, board.errors);
    if (board.errors == 0 && board.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
